@@ hdl/php_pkg.sv @@
package php_pkg;

    localparam logic [15:0] EtherIpv4 = 16'h0800;
    localparam logic [15:0] EtherIpv6 = 16'h86DD;

    localparam logic [1:0] NetIpv4    = 2'd0;
    localparam logic [1:0] NetIpv6    = 2'd1;
    localparam logic [1:0] NetUnknown = 2'd2;

    localparam logic [2:0] TrIcmp   = 3'd0;
    localparam logic [2:0] TrIcmpv6 = 3'd1;
    localparam logic [2:0] TrTcp    = 3'd2;
    localparam logic [2:0] TrUdp    = 3'd3;
    localparam logic [2:0] TrOther  = 3'd4;

    localparam logic [1:0] StatOk       = 2'd0;
    localparam logic [1:0] StatShort    = 2'd1;
    localparam logic [1:0] StatNegative = 2'd2;

    localparam int QueueDepth = 2;

    // Raw fields captured from one frame, handed from the capture stage
    // to the summary stage.
    typedef struct packed {
        logic [15:0] frame_len;
        logic [15:0] ether_kind;
        logic [5:0]  ip_header_bytes;
        logic [15:0] transport_start;
        logic [15:0] network_length;
        logic [7:0]  next_protocol;
        logic [31:0] port_words;
        logic [6:0]  tcp_header_bytes;
        logic [15:0] udp_length;
        logic [7:0]  icmp_kind;
        logic [63:0] ipv4_addresses;
    } capture_t;

    typedef struct packed {
        logic [31:0] packet_number;
        logic [1:0]  network_kind;
        logic [15:0] ether_kind_raw;
        logic [2:0]  transport_kind;
        logic [7:0]  next_protocol;
        logic [15:0] source_port;
        logic [15:0] dest_port;
        logic [7:0]  icmp_kind;
        logic [15:0] payload_bytes;
        logic [31:0] source_ipv4;
        logic [31:0] dest_ipv4;
        logic [1:0]  parse_status;
    } summary_t;

endpackage

@@ hdl/php_capture.sv @@
module php_capture
    import php_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       byte_valid,
    input  logic [7:0] frame_byte,
    input  logic       frame_end,
    output logic       cap_valid,
    output capture_t   cap_data
);

    logic [15:0] byte_offset_reg, byte_offset_next;
    logic [15:0] ether_kind_reg, ether_kind_next;
    logic [5:0]  ip_header_bytes_reg, ip_header_bytes_next;
    logic [15:0] transport_start_reg, transport_start_next;
    logic [15:0] network_length_reg, network_length_next;
    logic [7:0]  next_protocol_reg, next_protocol_next;
    logic [31:0] port_words_reg, port_words_next;
    logic [6:0]  tcp_header_bytes_reg, tcp_header_bytes_next;
    logic [15:0] udp_length_reg, udp_length_next;
    logic [7:0]  icmp_kind_reg, icmp_kind_next;
    logic [63:0] ipv4_addresses_reg, ipv4_addresses_next;

    logic        is_v4, is_v6;
    logic [15:0] pos, rel, tstart;
    logic [2:0]  lane;
    logic [16:0] frame_len_wide;

    always_comb begin
        pos = byte_offset_reg;
        lane = 3'd1 - pos[2:0];
        ether_kind_next = ether_kind_reg;
        ip_header_bytes_next = ip_header_bytes_reg;
        transport_start_next = transport_start_reg;
        network_length_next = network_length_reg;
        next_protocol_next = next_protocol_reg;
        port_words_next = port_words_reg;
        tcp_header_bytes_next = tcp_header_bytes_reg;
        udp_length_next = udp_length_reg;
        icmp_kind_next = icmp_kind_reg;
        ipv4_addresses_next = ipv4_addresses_reg;

        if (pos == 16'd12) ether_kind_next = {frame_byte, 8'd0};
        if (pos == 16'd13) ether_kind_next = {ether_kind_reg[15:8], frame_byte};
        is_v4 = (pos >= 16'd14) && (ether_kind_reg == EtherIpv4);
        is_v6 = (pos >= 16'd14) && (ether_kind_reg == EtherIpv6);

        tstart = transport_start_reg;
        if (is_v4) begin
            if (pos == 16'd14) begin
                ip_header_bytes_next = {frame_byte[3:0], 2'b00};
                tstart = 16'd14 + {10'd0, frame_byte[3:0], 2'b00};
            end
            if (pos == 16'd16) network_length_next = {frame_byte, 8'd0};
            if (pos == 16'd17) network_length_next = {network_length_reg[15:8], frame_byte};
            if (pos == 16'd23) next_protocol_next = frame_byte;
            if (pos >= 16'd26 && pos <= 16'd33) begin
                ipv4_addresses_next[8*lane +: 8] = frame_byte;
            end
        end
        if (is_v6) begin
            tstart = 16'd54;
            if (pos == 16'd18) network_length_next = {frame_byte, 8'd0};
            if (pos == 16'd19) network_length_next = {network_length_reg[15:8], frame_byte};
            if (pos == 16'd20) next_protocol_next = frame_byte;
        end
        transport_start_next = tstart;

        rel = pos - tstart;
        if ((is_v4 || is_v6) && pos >= tstart) begin
            if (rel == 16'd0) icmp_kind_next = frame_byte;
            if (rel < 16'd4) port_words_next[8*(3 - rel[1:0]) +: 8] = frame_byte;
            if (rel == 16'd4) udp_length_next = {frame_byte, 8'd0};
            if (rel == 16'd5) udp_length_next = {udp_length_reg[15:8], frame_byte};
            if (rel == 16'd12) tcp_header_bytes_next = {1'b0, frame_byte[7:4], 2'b00};
        end

        byte_offset_next = (byte_offset_reg != 16'hFFFF) ? byte_offset_reg + 16'd1
                                                         : byte_offset_reg;
    end

    // Address bytes 26..33 map to byte lanes 7..0 of the address word.
    // pos 26 -> lane 7; lane = 33 - pos, taken in 3 bits since 33-26 < 8.

    always_ff @(posedge aclk) begin
        if (!aresetn || (byte_valid && frame_end)) begin
            byte_offset_reg <= '0;
            ether_kind_reg <= '0;
            ip_header_bytes_reg <= '0;
            transport_start_reg <= '0;
            network_length_reg <= '0;
            next_protocol_reg <= '0;
            port_words_reg <= '0;
            tcp_header_bytes_reg <= '0;
            udp_length_reg <= '0;
            icmp_kind_reg <= '0;
            ipv4_addresses_reg <= '0;
        end else if (byte_valid) begin
            byte_offset_reg <= byte_offset_next;
            ether_kind_reg <= ether_kind_next;
            ip_header_bytes_reg <= ip_header_bytes_next;
            transport_start_reg <= transport_start_next;
            network_length_reg <= network_length_next;
            next_protocol_reg <= next_protocol_next;
            port_words_reg <= port_words_next;
            tcp_header_bytes_reg <= tcp_header_bytes_next;
            udp_length_reg <= udp_length_next;
            icmp_kind_reg <= icmp_kind_next;
            ipv4_addresses_reg <= ipv4_addresses_next;
        end
    end

    // Frame length saturates in 16 bits; every threshold used is far below that.
    assign frame_len_wide = {1'b0, pos} + 17'd1;

    assign cap_valid = byte_valid && frame_end;
    always_comb begin
        cap_data.frame_len = frame_len_wide[16] ? 16'hFFFF : frame_len_wide[15:0];
        cap_data.ether_kind = ether_kind_next;
        cap_data.ip_header_bytes = ip_header_bytes_next;
        cap_data.transport_start = transport_start_next;
        cap_data.network_length = network_length_next;
        cap_data.next_protocol = next_protocol_next;
        cap_data.port_words = port_words_next;
        cap_data.tcp_header_bytes = tcp_header_bytes_next;
        cap_data.udp_length = udp_length_next;
        cap_data.icmp_kind = icmp_kind_next;
        cap_data.ipv4_addresses = ipv4_addresses_next;
    end

endmodule

@@ hdl/php_queue.sv @@
module php_queue
    import php_pkg::*;
#(
    parameter int Depth = QueueDepth
) (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     wr_valid,
    output logic     wr_ready,
    input  capture_t wr_data,
    output logic     rd_valid,
    input  logic     rd_ready,
    output capture_t rd_data
);

    localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;

    capture_t          store_reg [Depth];
    logic [PtrW-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [PtrW:0]     count_reg;
    logic              do_wr, do_rd;

    assign wr_ready = (count_reg != Depth[PtrW:0]);
    assign rd_valid = (count_reg != '0);
    assign do_wr = wr_valid && wr_ready;
    assign do_rd = rd_valid && rd_ready;
    assign rd_data = store_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg <= '0;
        end else begin
            if (do_wr) begin
                wr_ptr_reg <= (wr_ptr_reg == PtrW'(Depth - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_rd) begin
                rd_ptr_reg <= (rd_ptr_reg == PtrW'(Depth - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            count_reg <= count_reg + {{PtrW{1'b0}}, do_wr} - {{PtrW{1'b0}}, do_rd};
        end
    end

    always_ff @(posedge aclk) begin
        if (do_wr) store_reg[wr_ptr_reg] <= wr_data;
    end

    assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= Depth[PtrW:0]) else $error("queue count overflow");
    assert property (@(posedge aclk) disable iff (!aresetn)
        (do_wr && !do_rd) |=> (count_reg == $past(count_reg) + 1'b1))
        else $error("queue count missed a write");
    assert property (@(posedge aclk) disable iff (!aresetn)
        (!do_wr && do_rd) |=> (count_reg == $past(count_reg) - 1'b1))
        else $error("queue count missed a read");

endmodule

@@ hdl/php_summary.sv @@
module php_summary
    import php_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     cap_valid,
    output logic     cap_ready,
    input  capture_t cap_data,
    output logic     sum_valid,
    input  logic     sum_ready,
    output summary_t sum_data
);

    logic [31:0] frame_counter_reg;
    logic        out_valid_reg;
    summary_t    out_data_reg;
    summary_t    s;
    logic        take;
    logic [15:0] need, l4min;
    logic signed [17:0] net, pay;
    logic        neg;

    always_comb begin
        s = '0;
        s.packet_number = frame_counter_reg + 32'd1;
        s.ether_kind_raw = cap_data.ether_kind;
        s.network_kind = NetUnknown;
        s.transport_kind = TrOther;
        l4min = '0;
        need = 16'd14;
        net = '0;
        pay = '0;
        neg = 1'b0;
        if (cap_data.frame_len >= 16'd14) begin
            if (cap_data.ether_kind == EtherIpv4) s.network_kind = NetIpv4;
            else if (cap_data.ether_kind == EtherIpv6) s.network_kind = NetIpv6;
        end
        if (s.network_kind != NetUnknown) begin
            s.next_protocol = cap_data.next_protocol;
            case (cap_data.next_protocol)
                8'd1: begin s.transport_kind = TrIcmp; l4min = 16'd8; end
                8'd58: begin s.transport_kind = TrIcmpv6; l4min = 16'd8; end
                8'd6: begin s.transport_kind = TrTcp; l4min = 16'd20; end
                8'd17: begin s.transport_kind = TrUdp; l4min = 16'd8; end
                default: begin s.transport_kind = TrOther; end
            endcase
            if (s.network_kind == NetIpv4) begin
                need = cap_data.transport_start + l4min;
                if (need < 16'd34) need = 16'd34;
                net = $signed({2'b00, cap_data.network_length})
                    - $signed({12'd0, cap_data.ip_header_bytes});
                if (net < 0) neg = 1'b1;
                s.source_ipv4 = cap_data.ipv4_addresses[63:32];
                s.dest_ipv4 = cap_data.ipv4_addresses[31:0];
            end else begin
                need = 16'd54 + l4min;
                net = $signed({2'b00, cap_data.network_length});
            end
            if (s.transport_kind == TrTcp || s.transport_kind == TrUdp) begin
                s.source_port = cap_data.port_words[31:16];
                s.dest_port = cap_data.port_words[15:0];
            end
            if (s.transport_kind == TrIcmp || s.transport_kind == TrIcmpv6) begin
                s.icmp_kind = cap_data.icmp_kind;
                pay = net - 18'sd8;
            end else if (s.transport_kind == TrTcp) begin
                pay = net - $signed({11'd0, cap_data.tcp_header_bytes});
            end else if (s.transport_kind == TrUdp) begin
                pay = $signed({2'b00, cap_data.udp_length}) - 18'sd8;
            end
            if (s.transport_kind != TrOther && pay < 0) neg = 1'b1;
            if (s.transport_kind != TrOther && pay > 0) s.payload_bytes = pay[15:0];
        end
        if (cap_data.frame_len < need) begin
            s.parse_status = StatShort;
            s.payload_bytes = '0;
        end else if (neg) begin
            s.parse_status = StatNegative;
            s.payload_bytes = '0;
        end
    end

    assign cap_ready = !out_valid_reg || sum_ready;
    assign take = cap_valid && cap_ready;
    assign sum_valid = out_valid_reg;
    assign sum_data = out_data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            frame_counter_reg <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            if (take) frame_counter_reg <= frame_counter_reg + 32'd1;
            if (cap_ready) out_valid_reg <= cap_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (take) out_data_reg <= s;
    end

    assert property (@(posedge aclk) disable iff (!aresetn)
        take |=> (out_valid_reg && out_data_reg.packet_number == frame_counter_reg))
        else $error("summary number does not match frame count");
    assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && out_data_reg.parse_status != StatOk)
            |-> (out_data_reg.payload_bytes == 16'd0))
        else $error("payload not cleared on bad status");
    assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && out_data_reg.network_kind == NetUnknown)
            |-> (out_data_reg.transport_kind == TrOther))
        else $error("transport class without network layer");

endmodule

@@ hdl/packet_header_parser.sv @@
// Ethernet header parser. Frame bytes arrive one per word on the s_ side,
// s_tlast marking the final byte; one summary word per frame leaves on the
// m_ side after the final byte. The capture stage takes a byte every cycle
// and never stalls except when its summary queue (QDepth entries, two by
// default) is full, which only happens if the m_ side holds back more than
// QDepth summaries. A summary passes through the queue, then the output
// register. IPv6 extension headers are not walked.
module packet_header_parser
    import php_pkg::*;
#(
    parameter int QDepth = QueueDepth
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [7:0]   s_tdata,   // frame_byte
    input  logic         s_tlast,   // frame_end
    output logic         m_tvalid,
    input  logic         m_tready,
    // packet_number[31:0], network_kind[33:32], ether_kind_raw[49:34],
    // transport_kind[52:50], next_protocol[60:53], source_port[76:61],
    // dest_port[92:77], icmp_kind[100:93], payload_bytes[116:101],
    // source_ipv4[148:117], dest_ipv4[180:149], parse_status[182:181], zero fill.
    output logic [183:0] m_tdata
);

    logic     cap_valid, q_wr_ready, q_rd_valid, q_rd_ready;
    capture_t cap_data, q_rd_data;
    summary_t sum_data;

    // Every byte is held off while the summary queue is full.
    assign s_tready = q_wr_ready;

    php_capture u_capture (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .byte_valid (s_tvalid && s_tready),
        .frame_byte (s_tdata),
        .frame_end  (s_tlast),
        .cap_valid  (cap_valid),
        .cap_data   (cap_data)
    );

    php_queue #(.Depth(QDepth)) u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_valid (cap_valid),
        .wr_ready (q_wr_ready),
        .wr_data  (cap_data),
        .rd_valid (q_rd_valid),
        .rd_ready (q_rd_ready),
        .rd_data  (q_rd_data)
    );

    php_summary u_summary (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cap_valid (q_rd_valid),
        .cap_ready (q_rd_ready),
        .cap_data  (q_rd_data),
        .sum_valid (m_tvalid),
        .sum_ready (m_tready),
        .sum_data  (sum_data)
    );

    assign m_tdata = {1'b0, sum_data.parse_status, sum_data.dest_ipv4, sum_data.source_ipv4,
                      sum_data.payload_bytes, sum_data.icmp_kind, sum_data.dest_port,
                      sum_data.source_port, sum_data.next_protocol,
                      sum_data.transport_kind, sum_data.ether_kind_raw,
                      sum_data.network_kind, sum_data.packet_number};

endmodule
